FILE: hw/rtl/modexp_pkg.sv
package modexp_pkg;

    // Operand width of base, exponent, modulus and residue.
    localparam int WIDTH = 32;

    // Bit counter width, enough to count WIDTH - 1 down to zero.
    localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_W  = ((3 * WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_REDUCE  = 5'b00010,
        ST_MUL_DBL = 5'b00100,
        ST_MUL_ADD = 5'b01000,
        ST_FINISH  = 5'b10000
    } state_t;

endpackage

FILE: hw/rtl/modular_exponentiation.sv
// Computes base_value ** exponent mod modulus for one request beat and returns one
// result beat. The base is first reduced by a restoring division; then
// square-and-multiply walks the exponent from its top bit, and each modular
// product is a shift-and-add of one doubling step per multiplier bit plus one
// add step for every set bit of the multiplier. All steps use a single modular
// add unit (add, then one compare and conditional subtract of the modulus). A
// zero modulus skips the computation and answers with modulus_zero set and
// residue zero. s_tready is high only while the block is idle; a finished
// result sits in an output register, so the next request can be taken while
// it waits for m_tready.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Fields from bit 0 up: base_value, exponent, modulus.
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // Fields from bit 0 up: residue.
    output logic [OUT_W-1:0] m_tdata,
    // Fields from bit 0 up: modulus_zero.
    output logic             m_tuser,
    output logic             m_tvalid,
    input  logic             m_tready
);

    state_t             state_reg, state_next;
    logic [WIDTH-1:0]   base_reg, base_next;
    logic [WIDTH-1:0]   exp_reg, exp_next;
    logic [WIDTH-1:0]   mod_reg, mod_next;
    logic [WIDTH-1:0]   r_reg, r_next;
    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]   mplier_reg, mplier_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   ecnt_reg, ecnt_next;
    logic               sq_reg, sq_next;
    logic               err_reg, err_next;
    logic [WIDTH-1:0]   res_out_reg, res_out_next;
    logic               err_out_reg, err_out_next;
    logic               valid_out_reg, valid_out_next;

    // Shared modular add unit: (a + b + cin), minus the modulus once if needed.
    logic [WIDTH-1:0]   unit_a, unit_b;
    logic               unit_cin;
    logic [WIDTH:0]     sum_w;
    logic [WIDTH+1:0]   diff_w;
    logic [WIDTH-1:0]   unit_res;

    assign sum_w    = {1'b0, unit_a} + {1'b0, unit_b} + {{WIDTH{1'b0}}, unit_cin};
    assign diff_w   = {1'b0, sum_w} - {2'b00, mod_reg};
    assign unit_res = diff_w[WIDTH+1] ? sum_w[WIDTH-1:0] : diff_w[WIDTH-1:0];

    logic             in_accept;
    logic             out_free;
    logic [WIDTH-1:0] r_init;
    logic             mul_step_done;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !valid_out_reg || m_tready;
    assign r_init    = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = OUT_W'(res_out_reg);
    assign m_tuser  = err_out_reg;
    assign m_tvalid = valid_out_reg;

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;
        sq_next        = sq_reg;
        err_next       = err_reg;
        res_out_next   = res_out_reg;
        err_out_next   = err_out_reg;
        valid_out_next = valid_out_reg;
        unit_a         = acc_reg;
        unit_b         = acc_reg;
        unit_cin       = 1'b0;
        mul_step_done  = 1'b0;

        // The consumer takes the waiting result.
        if (valid_out_reg && m_tready) begin
            valid_out_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    base_next   = s_tdata[WIDTH-1:0];
                    exp_next    = s_tdata[2*WIDTH-1:WIDTH];
                    mod_next    = s_tdata[3*WIDTH-1:2*WIDTH];
                    acc_next    = '0;
                    mplier_next = s_tdata[WIDTH-1:0];
                    cnt_next    = CNT_W'(WIDTH - 1);
                    if (s_tdata[3*WIDTH-1:2*WIDTH] == '0) begin
                        r_next     = '0;
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        err_next   = 1'b0;
                        state_next = ST_REDUCE;
                    end
                end
            end

            // Restoring division step: remainder = 2 * remainder + next base bit.
            ST_REDUCE: begin
                unit_cin    = mplier_reg[WIDTH-1];
                acc_next    = unit_res;
                mplier_next = {mplier_reg[WIDTH-2:0], 1'b0};
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    base_next   = unit_res;
                    r_next      = r_init;
                    acc_next    = '0;
                    mplier_next = r_init;
                    cnt_next    = CNT_W'(WIDTH - 1);
                    ecnt_next   = CNT_W'(WIDTH - 1);
                    sq_next     = 1'b1;
                    state_next  = ST_MUL_DBL;
                end
            end

            // Double the running product.
            ST_MUL_DBL: begin
                acc_next = unit_res;
                if (mplier_reg[WIDTH-1]) begin
                    state_next = ST_MUL_ADD;
                end else begin
                    mul_step_done = 1'b1;
                end
            end

            // Add the multiplicand for a set multiplier bit.
            ST_MUL_ADD: begin
                unit_b        = sq_reg ? r_reg : base_reg;
                acc_next      = unit_res;
                mul_step_done = 1'b1;
            end

            ST_FINISH: begin
                if (out_free) begin
                    res_out_next   = r_reg;
                    err_out_next   = err_reg;
                    valid_out_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Close one multiplier bit; at the last one, move on through the exponent.
        if (mul_step_done) begin
            mplier_next = {mplier_reg[WIDTH-2:0], 1'b0};
            cnt_next    = cnt_reg - CNT_W'(1);
            state_next  = ST_MUL_DBL;
            if (cnt_reg == '0) begin
                r_next   = unit_res;
                acc_next = '0;
                cnt_next = CNT_W'(WIDTH - 1);
                if (sq_reg && exp_reg[WIDTH-1]) begin
                    sq_next     = 1'b0;
                    mplier_next = unit_res;
                end else begin
                    exp_next    = {exp_reg[WIDTH-2:0], 1'b0};
                    ecnt_next   = ecnt_reg - CNT_W'(1);
                    sq_next     = 1'b1;
                    mplier_next = unit_res;
                    if (ecnt_reg == '0) begin
                        state_next = ST_FINISH;
                    end
                end
            end
        end
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_out_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_out_reg <= valid_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        mod_reg     <= mod_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        mplier_reg  <= mplier_next;
        cnt_reg     <= cnt_next;
        ecnt_reg    <= ecnt_next;
        sq_reg      <= sq_next;
        err_reg     <= err_next;
        res_out_reg <= res_out_next;
        err_out_reg <= err_out_next;
    end

endmodule
